// ===== sv/lphs_pkg.sv =====
// ----------------------------------------------------------------------------
// lphs_pkg
// Types and constants shared by the linear probing hash set files.
// ----------------------------------------------------------------------------
`default_nettype none

package lphs_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 11;

    localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_CHECK  = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic               success;
        logic [COUNT_W-1:0] entry_count;
    } t_res;

endpackage

`default_nettype wire

// ===== sv/linear_probe_hash_set.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Open-addressing hash set with a multiplicative hash and linear probing.
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  request   start, busy, i_req       taken when start && !busy
//  result    o_done, o_res            one cycle strobe, no back-pressure
//
//  after reset a clearing pass walks all the occupied marks, with busy high;
//  no item is taken meanwhile
//  an item goes from accept through a hash state and then probes slots, one
//  occupancy/key memory read per cycle, before the next item can be accepted
//  unused mode and insert into a full table end in the hash state
//  the result strobe is shown in the cycle busy falls
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_set #(
    parameter int INDEX_BITS = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire lphs_pkg::t_req i_req,
    output logic               busy,
    output logic               o_done,
    output lphs_pkg::t_res     o_res
);

    import lphs_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_HASH  = 4'b0100,
        ST_PROBE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]            r_mode, n_mode;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [INDEX_BITS-1:0] r_mag, n_mag;
    logic [INDEX_BITS-1:0] r_idx, n_idx;
    logic [INDEX_BITS-1:0] r_probe, n_probe;
    logic [INDEX_BITS-1:0] r_clr, n_clr;
    logic [INDEX_BITS:0]   r_count, n_count;
    logic                  r_done, n_done;
    t_res                  r_res, n_res;

    logic [KEY_W-1:0]      w_key_u;
    logic [KEY_W-1:0]      w_neg;
    logic [INDEX_BITS-1:0] w_mult_lo;
    logic [INDEX_BITS-1:0] w_hash;
    logic                  w_key_we;
    logic                  w_occ_we;
    logic                  w_occ_wdata;
    logic [INDEX_BITS-1:0] w_occ_waddr;
    logic [KEY_W-1:0]      w_rd_key;
    logic                  w_rd_occ;

    assign w_key_u   = i_req.key;
    assign w_neg     = ~w_key_u + 32'd1;
    assign w_mult_lo = HASH_MULT[INDEX_BITS-1:0];
    assign w_hash    = r_mag * w_mult_lo;

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    lphs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (2**INDEX_BITS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_idx),
        .i_wdata (r_key),
        .i_raddr (n_idx),
        .o_rdata (w_rd_key)
    );

    lphs_ram #(
        .WIDTH (1),
        .DEPTH (2**INDEX_BITS)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (w_occ_we),
        .i_waddr (w_occ_waddr),
        .i_wdata (w_occ_wdata),
        .i_raddr (n_idx),
        .o_rdata (w_rd_occ)
    );

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_key       = r_key;
        n_mag       = r_mag;
        n_idx       = r_idx;
        n_probe     = r_probe;
        n_clr       = r_clr;
        n_count     = r_count;
        n_done      = 1'b0;
        n_res       = r_res;
        w_key_we    = 1'b0;
        w_occ_we    = 1'b0;
        w_occ_wdata = 1'b0;
        w_occ_waddr = r_idx;

        unique case (r_state)
            ST_CLEAR: begin
                w_occ_we    = 1'b1;
                w_occ_waddr = r_clr;
                n_clr       = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_mode  = i_req.mode;
                    n_key   = w_key_u;
                    n_mag   = i_req.key[KEY_W-1] ? w_neg[INDEX_BITS-1:0]
                                                 : w_key_u[INDEX_BITS-1:0];
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                if ((r_mode != MODE_INSERT && r_mode != MODE_CHECK &&
                     r_mode != MODE_REMOVE) ||
                    (r_mode == MODE_INSERT && r_count[INDEX_BITS])) begin
                    n_done            = 1'b1;
                    n_res.success     = 1'b0;
                    n_res.entry_count = COUNT_W'(r_count);
                    n_state           = ST_IDLE;
                end else begin
                    n_idx   = w_hash;
                    n_probe = '0;
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!w_rd_occ) begin
                    // free slot ends the probe
                    if (r_mode == MODE_INSERT) begin
                        w_key_we    = 1'b1;
                        w_occ_we    = 1'b1;
                        w_occ_wdata = 1'b1;
                        n_count     = r_count + 1'b1;
                    end
                    n_done        = 1'b1;
                    n_res.success = (r_mode == MODE_INSERT);
                    n_state       = ST_IDLE;
                end else if (w_rd_key == r_key) begin
                    if (r_mode == MODE_REMOVE) begin
                        w_occ_we = 1'b1;
                        n_count  = r_count - 1'b1;
                    end
                    n_done        = 1'b1;
                    n_res.success = (r_mode != MODE_INSERT);
                    n_state       = ST_IDLE;
                end else if (&r_probe) begin
                    n_done        = 1'b1;
                    n_res.success = 1'b0;
                    n_state       = ST_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_probe = r_probe + 1'b1;
                end
                n_res.entry_count = COUNT_W'(n_count);
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_done  <= n_done;
            r_res   <= n_res;
        end
        r_mode  <= n_mode;
        r_key   <= n_key;
        r_mag   <= n_mag;
        r_idx   <= n_idx;
        r_probe <= n_probe;
    end

endmodule

`default_nettype wire

// ===== sv/lphs_ram.sv =====
// ----------------------------------------------------------------------------
// lphs_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/lphs_checker.sv =====
// ----------------------------------------------------------------------------
// lphs_checker
// Port-level checks for the linear probing hash set.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire lphs_pkg::t_req i_req,
    input wire logic           busy,
    input wire logic           o_done,
    input wire lphs_pkg::t_res o_res
);

    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // result is shown only once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // no two results back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // result ports only change with a result
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_res) |-> o_done)
        else $error("result ports changed without a result");

    // a failed item leaves the count unchanged
    a_fail_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_done ##1 (o_done && !o_res.success)) |->
            $stable(o_res.entry_count))
        else $error("count changed on a failed item");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

`default_nettype wire
